### design/whsp_pkg.sv
// Shared types and constants for the wheel speed PID drive.
// Holds drive, gain and bridge types, configuration indexes and queue sizing.
// Used by every module of the block; depends on nothing else.
package whsp_pkg;

    // Field widths fixed by the register map and the result format
    localparam int GAIN_W      = 16;
    localparam int DRIVE_W     = 9;
    localparam int PWM_W       = 8;
    localparam int INTEGRAL_W  = 24;
    localparam int Q_FRAC      = 8;
    localparam int FRAC_MASK   = (1 << Q_FRAC) - 1;
    localparam int DRIVE_LIMIT = 255;

    typedef logic signed [GAIN_W-1:0]  t_gain;
    typedef logic signed [DRIVE_W-1:0] t_drive;
    typedef logic [1:0]                t_bridge;

    // Bridge bit pairs, upper bit is dir_a
    localparam t_bridge BRIDGE_OFF = 2'b00;
    localparam t_bridge BRIDGE_FWD = 2'b01;
    localparam t_bridge BRIDGE_REV = 2'b10;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_P_GAIN    = 3'd0;
    localparam t_cfg_idx CFG_I_GAIN    = 3'd1;
    localparam t_cfg_idx CFG_D_GAIN    = 3'd2;
    localparam t_cfg_idx CFG_MIN_DRIVE = 3'd3;
    localparam t_cfg_idx CFG_MAX_DRIVE = 3'd4;
    localparam t_cfg_idx CFG_REVERSED  = 3'd5;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               not_empty;
    } t_q_stat;

endpackage

### design/whsp_front.sv
// Front end of the wheel speed PID drive: takes requests, forms the error
// and its difference, and multiplies them by the three gains.
// Depends on whsp_pkg; feeds whsp_queue.
module whsp_front #(
    parameter int RATE_WIDTH = 12,
    localparam int PW    = RATE_WIDTH + 1 + whsp_pkg::GAIN_W,
    localparam int PDW   = RATE_WIDTH + 2 + whsp_pkg::GAIN_W,
    localparam int JOB_W = 1 + 2 * PW + PDW
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_command,
    input  logic signed [RATE_WIDTH-1:0] i_measured_rate,
    input  logic signed [RATE_WIDTH-1:0] i_target_rate,
    input  whsp_pkg::t_gain              i_p_gain,
    input  whsp_pkg::t_gain              i_i_gain,
    input  whsp_pkg::t_gain              i_d_gain,
    input  logic                         i_motor_reversed,
    input  whsp_pkg::t_q_stat            i_q_stat,
    output logic                         o_push,
    output logic [JOB_W-1:0]             o_job
);
    import whsp_pkg::*;

    localparam int EW = RATE_WIDTH + 1;
    localparam int XW = RATE_WIDTH + 2;
    localparam logic signed [XW-1:0] ERR_MAX = XW'((1 << RATE_WIDTH) - 1);
    localparam logic signed [XW-1:0] ERR_MIN = XW'(-(1 << RATE_WIDTH));

    logic                 n_accept;
    logic signed [XW-1:0] n_tgt;
    logic signed [XW-1:0] n_diff;
    logic signed [EW-1:0] n_err;
    logic signed [XW-1:0] n_derr;
    logic [Q_CNT_W:0]     n_occ;
    logic signed [PW-1:0]  n_p_prod;
    logic signed [PW-1:0]  n_i_prod;
    logic signed [PDW-1:0] n_d_prod;

    logic                 r_f1_valid;
    logic                 r_f1_cmd;
    logic signed [EW-1:0] r_f1_err;
    logic signed [XW-1:0] r_f1_derr;
    logic signed [EW-1:0] r_prev_err;

    logic                  r_f2_valid;
    logic                  r_f2_cmd;
    logic signed [PW-1:0]  r_f2_p;
    logic signed [PW-1:0]  r_f2_i;
    logic signed [PDW-1:0] r_f2_d;

    // Hold requests off while the front stages and queue could fill up
    always_comb begin
        n_occ = (Q_CNT_W+1)'(i_q_stat.count) + (Q_CNT_W+1)'(r_f1_valid)
              + (Q_CNT_W+1)'(r_f2_valid);
    end
    assign o_stall  = (n_occ >= (Q_CNT_W+1)'(QUEUE_DEPTH));
    assign n_accept = i_valid && !o_stall;

    // Form the saturated error and its step against the previous error
    always_comb begin
        n_tgt = XW'(i_target_rate);
        if (i_motor_reversed) begin
            n_tgt = -n_tgt;
        end
        n_diff = n_tgt - XW'(i_measured_rate);
        if (n_diff > ERR_MAX) begin
            n_diff = ERR_MAX;
        end else if (n_diff < ERR_MIN) begin
            n_diff = ERR_MIN;
        end
        n_err  = EW'(n_diff);
        n_derr = XW'(n_err) - XW'(r_prev_err);
    end

    // Stage one: register the error terms and track the previous error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_prev_err <= '0;
        end else begin
            r_f1_valid <= n_accept;
            if (n_accept) begin
                r_prev_err <= i_command ? '0 : n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_f1_cmd  <= i_command;
            r_f1_err  <= n_err;
            r_f1_derr <= n_derr;
        end
    end

    // Stage two: three gain products side by side
    always_comb begin
        n_p_prod = PW'(r_f1_err) * PW'(i_p_gain);
        n_i_prod = PW'(r_f1_err) * PW'(i_i_gain);
        n_d_prod = PDW'(r_f1_derr) * PDW'(i_d_gain);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_valid <= 1'b0;
        end else begin
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f1_valid) begin
            r_f2_cmd <= r_f1_cmd;
            r_f2_p   <= n_p_prod;
            r_f2_i   <= n_i_prod;
            r_f2_d   <= n_d_prod;
        end
    end

    assign o_push = r_f2_valid;
    assign o_job  = {r_f2_cmd, r_f2_p, r_f2_i, r_f2_d};

endmodule

### design/whsp_queue.sv
// Short request queue between the front end and the back end.
// Depends on whsp_pkg for its depth and status struct.
module whsp_queue #(
    parameter int WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_head,
    output whsp_pkg::t_q_stat o_stat
);
    import whsp_pkg::*;

    logic [WIDTH-1:0]   r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store incoming requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_head           = r_mem[r_rd_ptr];
    assign o_stat.count     = r_count;
    assign o_stat.not_empty = (r_count != '0);

endmodule

### design/whsp_back.sv
// Back end of the wheel speed PID drive: integral update, PID sum and
// clamps, then the bridge update and the output register.
// Depends on whsp_pkg; takes requests from whsp_queue.
module whsp_back #(
    parameter int RATE_WIDTH     = 12,
    parameter int INTEGRAL_LIMIT = 250,
    localparam int PW    = RATE_WIDTH + 1 + whsp_pkg::GAIN_W,
    localparam int PDW   = RATE_WIDTH + 2 + whsp_pkg::GAIN_W,
    localparam int JOB_W = 1 + 2 * PW + PDW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  whsp_pkg::t_q_stat i_q_stat,
    input  logic [JOB_W-1:0]  i_head,
    output logic              o_pop,
    input  whsp_pkg::t_drive  i_min_drive,
    input  whsp_pkg::t_drive  i_max_drive,
    output logic              o_valid,
    input  logic              i_stall,
    output whsp_pkg::t_drive  o_drive,
    output logic [whsp_pkg::PWM_W-1:0] o_pwm_duty,
    output logic              o_dir_a,
    output logic              o_dir_b,
    output logic              o_direction_switch,
    output logic              o_drive_changed
);
    import whsp_pkg::*;

    localparam int QW    = PW - Q_FRAC;
    localparam int QDW   = PDW - Q_FRAC;
    localparam int IW    = ((QW > INTEGRAL_W) ? QW : INTEGRAL_W) + 1;
    localparam int BIG   = (QDW > INTEGRAL_W) ? QDW : INTEGRAL_W;
    localparam int SUMW  = BIG + 2;
    localparam logic signed [IW-1:0]   INT_HI = IW'(INTEGRAL_LIMIT);
    localparam logic signed [IW-1:0]   INT_LO = IW'(-(1 << (INTEGRAL_W - 1)));
    localparam logic signed [SUMW-1:0] LIM_HI = SUMW'(DRIVE_LIMIT);
    localparam logic signed [SUMW-1:0] LIM_LO = SUMW'(-DRIVE_LIMIT);

    logic                  n_adv;
    logic                  n_cmd;
    logic signed [PW-1:0]  n_p_raw;
    logic signed [PW-1:0]  n_i_raw;
    logic signed [PDW-1:0] n_d_raw;
    logic signed [QW-1:0]  n_p_q;
    logic signed [QW-1:0]  n_i_q;
    logic signed [QDW-1:0] n_d_q;
    logic signed [IW-1:0]  n_int_sum;

    logic signed [SUMW-1:0] n_sum;
    logic signed [SUMW-1:0] n_hi;
    logic signed [SUMW-1:0] n_lo;
    t_drive                 n_drive;

    logic    n_step;
    logic    n_cross;
    logic    n_apply;
    t_drive  n_applied;
    t_drive  n_mag;
    t_bridge n_bridge;

    logic                          r_b1_valid;
    logic                          r_b1_cmd;
    logic signed [QW-1:0]          r_b1_prop;
    logic signed [QDW-1:0]         r_b1_deriv;
    logic signed [INTEGRAL_W-1:0]  r_integral;

    logic   r_b2_valid;
    logic   r_b2_cmd;
    t_drive r_b2_drive;

    t_drive  r_applied;
    t_bridge r_bridge;

    logic             r_o_valid;
    t_drive           r_o_drive;
    logic [PWM_W-1:0] r_o_pwm;
    t_bridge          r_o_dir;
    logic             r_o_switch;
    logic             r_o_changed;

    // Whole back pipeline moves when the output register is free
    assign n_adv = !r_o_valid || !i_stall;
    assign o_pop = n_adv && i_q_stat.not_empty;

    // Unpack the head request and truncate the products toward zero
    always_comb begin
        n_cmd   = i_head[JOB_W-1];
        n_p_raw = $signed(i_head[JOB_W-2 -: PW]);
        n_i_raw = $signed(i_head[JOB_W-2-PW -: PW]);
        n_d_raw = $signed(i_head[PDW-1:0]);
        n_p_q   = QW'((n_p_raw + PW'(n_p_raw[PW-1] ? FRAC_MASK : 0)) >>> Q_FRAC);
        n_i_q   = QW'((n_i_raw + PW'(n_i_raw[PW-1] ? FRAC_MASK : 0)) >>> Q_FRAC);
        n_d_q   = QDW'((n_d_raw + PDW'(n_d_raw[PDW-1] ? FRAC_MASK : 0)) >>> Q_FRAC);
        n_int_sum = IW'(r_integral) + IW'(n_i_q);
        if (n_int_sum > INT_HI) begin
            n_int_sum = INT_HI;
        end
        if (n_int_sum < INT_LO) begin
            n_int_sum = INT_LO;
        end
    end

    // Stage one: integral update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_integral <= '0;
        end else if (n_adv) begin
            r_b1_valid <= i_q_stat.not_empty;
            if (o_pop) begin
                r_integral <= n_cmd ? '0 : INTEGRAL_W'(n_int_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_cmd   <= n_cmd;
            r_b1_prop  <= n_p_q;
            r_b1_deriv <= n_d_q;
        end
    end

    // Sum the three terms, then the drive window and the hard limit
    always_comb begin
        n_hi  = SUMW'(i_max_drive);
        n_lo  = SUMW'(i_min_drive);
        n_sum = SUMW'(r_b1_prop) + SUMW'(r_integral) + SUMW'(r_b1_deriv);
        if (n_sum >= n_hi) begin
            n_sum = n_hi;
        end
        if (n_sum <= n_lo) begin
            n_sum = n_lo;
        end
        if (n_sum > LIM_HI) begin
            n_sum = LIM_HI;
        end
        if (n_sum < LIM_LO) begin
            n_sum = LIM_LO;
        end
        n_drive = DRIVE_W'(n_sum);
    end

    // Stage two: clamped drive
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid <= 1'b0;
        end else if (n_adv) begin
            r_b2_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv && r_b1_valid) begin
            r_b2_cmd   <= r_b1_cmd;
            r_b2_drive <= n_drive;
        end
    end

    // Apply the drive to the bridge; a sign crossing sets new direction bits
    always_comb begin
        n_step    = r_b2_valid && !r_b2_cmd;
        n_cross   = ((r_applied <= t_drive'(0)) && (r_b2_drive >= t_drive'(0)))
                 || ((r_applied >= t_drive'(0)) && (r_b2_drive <= t_drive'(0)));
        n_apply   = n_step && (r_b2_drive != r_applied);
        n_applied = n_apply ? r_b2_drive : r_applied;
        n_bridge  = r_bridge;
        if (n_apply && n_cross) begin
            n_bridge = r_b2_drive[DRIVE_W-1] ? BRIDGE_REV : BRIDGE_FWD;
        end
        n_mag = n_applied[DRIVE_W-1] ? -n_applied : n_applied;
    end

    // Stage three: bridge state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_applied <= '0;
            r_bridge  <= BRIDGE_OFF;
        end else if (n_adv) begin
            r_o_valid <= r_b2_valid;
            r_applied <= n_applied;
            r_bridge  <= n_bridge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv && r_b2_valid) begin
            r_o_drive   <= n_applied;
            r_o_pwm     <= n_mag[PWM_W-1:0];
            r_o_dir     <= n_bridge;
            r_o_switch  <= n_apply && n_cross;
            r_o_changed <= n_apply;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_drive            = r_o_drive;
    assign o_pwm_duty         = r_o_pwm;
    assign o_dir_a            = r_o_dir[1];
    assign o_dir_b            = r_o_dir[0];
    assign o_direction_switch = r_o_switch;
    assign o_drive_changed    = r_o_changed;

endmodule

### design/wheel_speed_pid_drive_top.sv
// Top level of the wheel speed PID drive: configuration registers and the
// front end, request queue and back end. Depends on whsp_pkg, whsp_front,
// whsp_queue and whsp_back.
//
// One request per clock is taken and one result per clock is given in steady
// flow, when neither o_stall nor i_stall holds it. A request passes through two
// front stages (error, gain products) and the four-entry queue, then the integral
// stage, the sum-and-clamp stage and the bridge/output register.
// o_stall rises once the front stages and queue hold four requests between
// them, so a stalled output backs requests up into the queue first. A command
// of 1 clears the integral and previous error and reports the held drive.
// Write configuration only while no request is in flight.
module wheel_speed_pid_drive_top #(
    parameter int RATE_WIDTH     = 12,
    parameter int INTEGRAL_LIMIT = 250
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  whsp_pkg::t_cfg_idx              i_cfg_index,
    input  logic [whsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_command,
    input  logic signed [RATE_WIDTH-1:0]    i_measured_rate,
    input  logic signed [RATE_WIDTH-1:0]    i_target_rate,
    output logic                            o_valid,
    input  logic                            i_stall,
    output whsp_pkg::t_drive                o_drive,
    output logic [whsp_pkg::PWM_W-1:0]      o_pwm_duty,
    output logic                            o_dir_a,
    output logic                            o_dir_b,
    output logic                            o_direction_switch,
    output logic                            o_drive_changed
);
    import whsp_pkg::*;

    localparam int PW    = RATE_WIDTH + 1 + GAIN_W;
    localparam int PDW   = RATE_WIDTH + 2 + GAIN_W;
    localparam int JOB_W = 1 + 2 * PW + PDW;

    t_gain  r_p_gain;
    t_gain  r_i_gain;
    t_gain  r_d_gain;
    t_drive r_min_drive;
    t_drive r_max_drive;
    logic   r_motor_reversed;

    logic             w_push;
    logic             w_pop;
    logic [JOB_W-1:0] w_job;
    logic [JOB_W-1:0] w_head;
    t_q_stat          w_q_stat;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_gain         <= '0;
            r_i_gain         <= '0;
            r_d_gain         <= '0;
            r_min_drive      <= t_drive'(-DRIVE_LIMIT);
            r_max_drive      <= t_drive'(DRIVE_LIMIT);
            r_motor_reversed <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_P_GAIN: begin
                    r_p_gain <= i_cfg_data;
                end
                CFG_I_GAIN: begin
                    r_i_gain <= i_cfg_data;
                end
                CFG_D_GAIN: begin
                    r_d_gain <= i_cfg_data;
                end
                CFG_MIN_DRIVE: begin
                    r_min_drive <= i_cfg_data[DRIVE_W-1:0];
                end
                CFG_MAX_DRIVE: begin
                    r_max_drive <= i_cfg_data[DRIVE_W-1:0];
                end
                CFG_REVERSED: begin
                    r_motor_reversed <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    whsp_front #(
        .RATE_WIDTH (RATE_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_measured_rate  (i_measured_rate),
        .i_target_rate    (i_target_rate),
        .i_p_gain         (r_p_gain),
        .i_i_gain         (r_i_gain),
        .i_d_gain         (r_d_gain),
        .i_motor_reversed (r_motor_reversed),
        .i_q_stat         (w_q_stat),
        .o_push           (w_push),
        .o_job            (w_job)
    );

    whsp_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    whsp_back #(
        .RATE_WIDTH     (RATE_WIDTH),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_stat           (w_q_stat),
        .i_head             (w_head),
        .o_pop              (w_pop),
        .i_min_drive        (r_min_drive),
        .i_max_drive        (r_max_drive),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_drive            (o_drive),
        .o_pwm_duty         (o_pwm_duty),
        .o_dir_a            (o_dir_a),
        .o_dir_b            (o_dir_b),
        .o_direction_switch (o_direction_switch),
        .o_drive_changed    (o_drive_changed)
    );

endmodule

### design/whsp_checker.sv
// Port-level checks on the wheel speed PID drive results.
// Depends on whsp_pkg; bound to wheel_speed_pid_drive_top below.
module whsp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input whsp_pkg::t_drive           o_drive,
    input logic [whsp_pkg::PWM_W-1:0] o_pwm_duty,
    input logic                       o_dir_a,
    input logic                       o_dir_b,
    input logic                       o_direction_switch,
    input logic                       o_drive_changed
);
    import whsp_pkg::*;

    // Hold a stalled result
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_drive) && $stable(o_pwm_duty)
            && $stable(o_dir_a) && $stable(o_dir_b))
        else $error("stalled result changed");

    // A non-zero drive has exactly one bridge input high, matching its sign
    a_dir_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_drive != t_drive'(0)) |->
            (o_dir_a == o_drive[DRIVE_W-1]) && (o_dir_a != o_dir_b))
        else $error("bridge bits disagree with drive sign");

    // A direction switch only comes with a changed drive
    a_switch_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_direction_switch |-> o_drive_changed)
        else $error("direction switch without drive change");

    // PWM duty is the drive magnitude
    a_pwm_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pwm_duty == (o_drive[DRIVE_W-1] ? PWM_W'(-o_drive)
                                                       : o_drive[PWM_W-1:0])))
        else $error("pwm duty differs from drive magnitude");

endmodule

bind wheel_speed_pid_drive_top whsp_checker u_whsp_checker (.*);

### verif/tb_wheel_speed_pid_drive_top.sv
// Self-checking bench for wheel_speed_pid_drive_top: sends directed and random speed
// samples under random idling, predicts each drive result and compares every field.
// Depends on whsp_pkg and the design sources of the block.
module tb_wheel_speed_pid_drive_top;
    import whsp_pkg::*;

    localparam int RATE_W        = 12;
    localparam int INTEG_LIMIT   = 250;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 48;
    localparam int IDLE_LIMIT    = 1000;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 105;

    localparam int RATE_MIN = -(1 << (RATE_W - 1));
    localparam int RATE_MAX = (1 << (RATE_W - 1)) - 1;
    localparam int GAIN_MIN = -(1 << (GAIN_W - 1));
    localparam int GAIN_MAX = (1 << (GAIN_W - 1)) - 1;
    localparam int Q_ONE    = 1 << Q_FRAC;

    localparam longint ERR_MAX     = (longint'(1) << RATE_W) - 1;
    localparam longint ERR_MIN     = -(longint'(1) << RATE_W);
    localparam longint INTEG_FLOOR = -(longint'(1) << (INTEGRAL_W - 1));

    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Register indexes beyond the map, writes there must be dropped
    localparam t_cfg_idx CFG_UNMAPPED_LO = 3'd6;
    localparam t_cfg_idx CFG_UNMAPPED_HI = 3'd7;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} t_stall_mode;

    typedef struct packed {
        t_drive             drive;
        logic [PWM_W-1:0]   pwm_duty;
        logic               dir_a;
        logic               dir_b;
        logic               direction_switch;
        logic               drive_changed;
    } t_drive_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    t_cfg_idx                 i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_command;
    logic signed [RATE_W-1:0] i_measured_rate;
    logic signed [RATE_W-1:0] i_target_rate;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    t_drive                   o_drive;
    logic [PWM_W-1:0]         o_pwm_duty;
    logic                     o_dir_a;
    logic                     o_dir_b;
    logic                     o_direction_switch;
    logic                     o_drive_changed;

    // Predictor copy of registers and controller state
    longint  kp, ki, kd, drive_lo, drive_hi;
    logic    reversed;
    longint  integ_sum, last_err, applied;
    t_bridge bridge;

    t_drive_result expected_drives[$];

    // Sender and receiver pacing
    int          burst_left = 0;
    int          gap_left = 0;
    logic        steady_send = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          hold_left = 0;
    int          run_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    logic [7:0]  stall_pattern = '0;
    int          seq_target = 0;
    int          idle_cycles = 0;

    int requests_sent = 0;
    int clears_sent = 0;
    int settings_written = 0;
    int results_checked = 0;
    int mismatches = 0;

    wheel_speed_pid_drive_top #(
        .RATE_WIDTH     (RATE_W),
        .INTEGRAL_LIMIT (INTEG_LIMIT)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_command          (i_command),
        .i_measured_rate    (i_measured_rate),
        .i_target_rate      (i_target_rate),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_drive            (o_drive),
        .o_pwm_duty         (o_pwm_duty),
        .o_dir_a            (o_dir_a),
        .o_dir_b            (o_dir_b),
        .o_direction_switch (o_direction_switch),
        .o_drive_changed    (o_drive_changed)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void reset_model();
        kp        = 0;
        ki        = 0;
        kd        = 0;
        drive_lo  = -DRIVE_LIMIT;
        drive_hi  = DRIVE_LIMIT;
        reversed  = 1'b0;
        integ_sum = 0;
        last_err  = 0;
        applied   = 0;
        bridge    = BRIDGE_OFF;
    endfunction

    function automatic void apply_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_P_GAIN:    kp = t_gain'(data);
            CFG_I_GAIN:    ki = t_gain'(data);
            CFG_D_GAIN:    kd = t_gain'(data);
            CFG_MIN_DRIVE: drive_lo = t_drive'(data);
            CFG_MAX_DRIVE: drive_hi = t_drive'(data);
            CFG_REVERSED:  reversed = data[0];
            default: ;
        endcase
    endfunction

    // Advance the controller by one request and return the drive it reports
    function automatic t_drive_result predict_drive(input logic cmd, input int meas,
                                                    input int targ);
        longint        err, prop, deriv, total;
        logic          crossed, moved;
        t_drive_result res;
        crossed = 1'b0;
        moved   = 1'b0;
        if (cmd == CMD_CLEAR) begin
            integ_sum = 0;
            last_err  = 0;
        end else begin
            err = (reversed ? -targ : targ) - meas;
            if (err > ERR_MAX) err = ERR_MAX;
            if (err < ERR_MIN) err = ERR_MIN;
            // gain products truncate toward zero
            prop      = err * kp / Q_ONE;
            integ_sum = integ_sum + err * ki / Q_ONE;
            if (integ_sum > INTEG_LIMIT) integ_sum = INTEG_LIMIT;
            if (integ_sum < INTEG_FLOOR) integ_sum = INTEG_FLOOR;
            deriv    = (err - last_err) * kd / Q_ONE;
            last_err = err;
            // lower clamp applied last, so it wins on a conflict
            total = prop + integ_sum + deriv;
            if (total >= drive_hi) total = drive_hi;
            if (total <= drive_lo) total = drive_lo;
            if (total > DRIVE_LIMIT) total = DRIVE_LIMIT;
            if (total < -DRIVE_LIMIT) total = -DRIVE_LIMIT;
            if (total != applied) begin
                moved = 1'b1;
                if ((applied <= 0 && total >= 0) || (applied >= 0 && total <= 0)) begin
                    crossed = 1'b1;
                    bridge  = (total < 0) ? BRIDGE_REV : BRIDGE_FWD;
                end
                applied = total;
            end
        end
        res.drive            = t_drive'(applied);
        res.pwm_duty         = PWM_W'((applied < 0) ? -applied : applied);
        res.dir_a            = bridge[1];
        res.dir_b            = bridge[0];
        res.direction_switch = crossed;
        res.drive_changed    = moved;
        return res;
    endfunction

    function automatic int rand_rate();
        return int'($urandom_range(0, (1 << RATE_W) - 1)) + RATE_MIN;
    endfunction

    function automatic int pick_gain();
        t_gain g;
        g = t_gain'($urandom);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return GAIN_MIN;
            2: return GAIN_MAX;
            3, 4: return int'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE;
            default: return int'(g);
        endcase
    endfunction

    function automatic int pick_drive_bound(input int fallback);
        if ($urandom_range(0, 2) == 0)
            return int'($urandom_range(0, 2 * DRIVE_LIMIT)) - DRIVE_LIMIT;
        return fallback;
    endfunction

    // Drop valid, hold until every drive result is back, then let the pipe settle
    task automatic drain_requests();
        i_valid <= 1'b0;
        while (expected_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        apply_reg(idx, value[CFG_DATA_W-1:0]);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int p, input int i, input int d, input int lo,
                             input int hi, input int rev);
        drain_requests();
        write_reg(CFG_P_GAIN, p);
        write_reg(CFG_I_GAIN, i);
        write_reg(CFG_D_GAIN, d);
        write_reg(CFG_MIN_DRIVE, lo);
        write_reg(CFG_MAX_DRIVE, hi);
        write_reg(CFG_REVERSED, rev);
        settings_written++;
    endtask

    // Offer one request, wait for it to be taken and queue its expected drive
    task automatic send_request(input logic cmd, input int meas, input int targ);
        t_drive_result want;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left != 0 && !steady_send) begin
            i_valid <= 1'b0;
            repeat (gap_left) @(posedge i_clk);
        end
        gap_left = 0;
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_measured_rate <= meas[RATE_W-1:0];
        i_target_rate   <= targ[RATE_W-1:0];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want = predict_drive(cmd, meas, targ);
        expected_drives.push_back(want);
        burst_left--;
        requests_sent++;
        if (cmd == CMD_CLEAR) clears_sent++;
    endtask

    // Mostly steady tracking around a held target, some clears and some noise
    task automatic send_random_item(input logic windup);
        int kind, eff, meas;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            send_request(CMD_CLEAR, rand_rate(), rand_rate());
        end else if (windup) begin
            send_request(CMD_STEP, RATE_MAX - int'($urandom_range(0, 15)),
                         RATE_MIN + int'($urandom_range(0, 15)));
        end else if (kind <= 4) begin
            send_request(CMD_STEP, rand_rate(), rand_rate());
        end else begin
            if ($urandom_range(0, 24) == 0)
                seq_target = rand_rate() / (($urandom_range(0, 1) == 0) ? 1 : 16);
            eff  = reversed ? -seq_target : seq_target;
            meas = eff + int'($urandom_range(0, 64)) - 32;
            if (meas > RATE_MAX) meas = RATE_MAX;
            if (meas < RATE_MIN) meas = RATE_MIN;
            send_request(CMD_STEP, meas, seq_target);
        end
    endtask

    // Zero gains after reset: drive stays at 0 and the bridge stays low
    task automatic test_reset_defaults();
        send_request(CMD_STEP, rand_rate(), rand_rate());
        send_request(CMD_CLEAR, RATE_MAX, RATE_MIN);
    endtask

    // Unit P gain, unmapped writes dropped, then steps through and onto zero
    task automatic test_register_map();
        configure(Q_ONE, 0, 0, -DRIVE_LIMIT, DRIVE_LIMIT, 0);
        write_reg(CFG_UNMAPPED_LO, int'($urandom));
        write_reg(CFG_UNMAPPED_HI, -1);
        send_request(CMD_STEP, 0, 10);
        send_request(CMD_STEP, 0, 10);
        send_request(CMD_STEP, 0, 0);
        send_request(CMD_STEP, 5, 0);
        send_request(CMD_STEP, 0, -3);
    endtask

    // Rate extremes, with the reversed target pushing the error past its range
    task automatic test_error_saturation();
        configure(GAIN_MAX, 0, GAIN_MIN, -DRIVE_LIMIT, DRIVE_LIMIT, 1);
        send_request(CMD_STEP, RATE_MIN, RATE_MIN);
        send_request(CMD_STEP, RATE_MAX, RATE_MAX);
        configure(GAIN_MIN, 0, GAIN_MAX, -DRIVE_LIMIT, DRIVE_LIMIT, 0);
        send_request(CMD_STEP, RATE_MAX, RATE_MIN);
        send_request(CMD_STEP, RATE_MIN, RATE_MAX);
        send_request(CMD_STEP, 0, 0);
    endtask

    // Lower drive bound above the upper one
    task automatic test_clamp_conflict();
        configure(Q_ONE, 0, 0, 100, -100, 0);
        send_request(CMD_STEP, 0, 50);
        send_request(CMD_STEP, 0, -50);
        configure(Q_ONE, 0, 0, DRIVE_LIMIT, -DRIVE_LIMIT, 0);
        send_request(CMD_STEP, 0, -1);
    endtask

    // Build up integral, clear it mid-run, then reverse
    task automatic test_clear_command();
        configure(0, GAIN_MAX, Q_ONE, -DRIVE_LIMIT, DRIVE_LIMIT, 0);
        send_request(CMD_STEP, 0, 40);
        send_request(CMD_STEP, 0, 40);
        send_request(CMD_CLEAR, RATE_MIN, RATE_MAX);
        send_request(CMD_STEP, 0, -40);
    endtask

    // Long receiver hold-off while requests keep coming, then a full drain
    task automatic test_backpressure();
        configure(pick_gain(), pick_gain(), pick_gain(), -DRIVE_LIMIT, DRIVE_LIMIT, 0);
        steady_send = 1'b1;
        hold_req <= ~hold_req;
        repeat (20) send_random_item(1'b0);
        steady_send = 1'b0;
        drain_requests();
    endtask

    task automatic test_random_phases();
        logic windup;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            windup = (phase % 5 == 3);
            if (windup)
                configure(pick_gain(), (phase % 2 == 1) ? GAIN_MAX : GAIN_MIN, pick_gain(),
                          -DRIVE_LIMIT, DRIVE_LIMIT, 0);
            else
                configure(pick_gain(), pick_gain(), pick_gain(),
                          pick_drive_bound(-DRIVE_LIMIT), pick_drive_bound(DRIVE_LIMIT),
                          $urandom_range(0, 1));
            seq_target = rand_rate();
            repeat (PHASE_ITEMS) send_random_item(windup);
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_P_GAIN;
        i_cfg_data      <= '0;
        i_valid         <= 1'b0;
        i_command       <= CMD_STEP;
        i_measured_rate <= '0;
        i_target_rate   <= '0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_map();
        test_error_saturation();
        test_clamp_conflict();
        test_clear_command();
        test_backpressure();
        test_random_phases();
        drain_requests();

        $display("Run covered %0d requests (%0d clear commands) under %0d register settings.",
                 requests_sent, clears_sent, settings_written);
        $display("%0d drive results compared, %0d field mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && expected_drives.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            i_stall  <= 1'b1;
            hold_left = HOLD_CYCLES - 1;
        end else begin
            if (run_left == 0) begin
                run_left      = $urandom_range(10, 80);
                stall_mode    = t_stall_mode'($urandom_range(0, 3));
                stall_pattern = 8'($urandom);
            end
            run_left = run_left - 1;
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default: begin
                    i_stall <= stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                end
            endcase
        end
    end

    task automatic compare_field(input string name, input logic signed [15:0] want_v,
                                 input logic signed [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Match each accepted drive result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_drive_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_drives.size() == 0) begin
                $error("drive result %0d with no request outstanding", o_drive);
                mismatches++;
            end else begin
                want = expected_drives.pop_front();
                compare_field("drive", 16'(want.drive), 16'(o_drive));
                compare_field("pwm_duty", 16'(want.pwm_duty), 16'(o_pwm_duty));
                compare_field("dir_a", 16'(want.dir_a), 16'(o_dir_a));
                compare_field("dir_b", 16'(want.dir_b), 16'(o_dir_b));
                compare_field("direction_switch", 16'(want.direction_switch),
                              16'(o_direction_switch));
                compare_field("drive_changed", 16'(want.drive_changed),
                              16'(o_drive_changed));
                results_checked++;
            end
        end
    end

    // Stop a hung run: too long without any request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $error("no request or result moved for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
